@@ sv/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ sv/hhe_pkg.sv @@
`default_nettype none

package hhe_pkg;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_LO_H  = 8'h68;
    localparam logic [7:0] CH_LO_O  = 8'h6F;
    localparam logic [7:0] CH_LO_S  = 8'h73;
    localparam logic [7:0] CH_LO_T  = 8'h74;

    localparam logic [31:0] WORD_MAIL       = 32'h6D61696C;
    localparam logic [23:0] WORD_ONE_EIGHT_NINE = 24'h313839;
    localparam logic [31:0] WORD_TWO_ONE_CN = 32'h3231636E;

    localparam logic [7:0] MAX_HOST_LEN_RESET = 8'd64;
    localparam logic       MAIL_EN_RESET      = 1'b1;

    // register selects, from paddr[2]
    localparam logic REG_MAX_HOST_LEN = 1'b0;
    localparam logic REG_MAIL_EN      = 1'b1;

    localparam int OUT_DATA_W = 16;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // what one request byte produced: optional character, optional summary
    typedef struct packed {
        logic       has_char;
        logic [7:0] host_char;
        logic       has_sum;
        logic       found;
        logic       mail;
        logic       special;
    } result_evt_t;

    function automatic logic [7:0] lower_letter(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ sv/hhe_front.sv @@
`default_nettype none

module hhe_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          max_host_len,
    input  logic                mail_check_enable,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          in_byte,
    input  logic                in_last,
    input  logic                q_full,
    output logic                evt_push,
    output hhe_pkg::result_evt_t evt
);
    import hhe_pkg::*;

    typedef enum logic [1:0] {
        PH_SEARCH  = 2'd0,
        PH_CAPTURE = 2'd1,
        PH_DONE    = 2'd2
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [39:0] recent_reg, recent_next;
    logic [7:0]  count_reg, count_next;
    logic [23:0] host_hist_reg, host_hist_next;
    logic        mail_reg, mail_next;
    logic        one89_reg, one89_next;
    logic        cn_reg, cn_next;

    logic        accept;
    result_evt_t e;

    assign in_ready = !q_full;
    assign accept   = in_valid && !q_full;
    assign evt      = e;
    assign evt_push = accept && (e.has_char || e.has_sum);

    always_comb
    begin
        logic        host_hit;
        logic        blank_hit;
        logic        term;
        logic [31:0] w;
        logic [7:0]  cnt_v;

        phase_next     = phase_reg;
        recent_next    = recent_reg;
        count_next     = count_reg;
        host_hist_next = host_hist_reg;
        mail_next      = mail_reg;
        one89_next     = one89_reg;
        cn_next        = cn_reg;
        e              = '0;

        host_hit  = recent_reg[39:32] == CH_LF &&
                    lower_letter(recent_reg[31:24]) == CH_LO_H &&
                    lower_letter(recent_reg[23:16]) == CH_LO_O &&
                    lower_letter(recent_reg[15:8])  == CH_LO_S &&
                    lower_letter(recent_reg[7:0])   == CH_LO_T &&
                    in_byte == CH_COLON;
        blank_hit = recent_reg[15:8] == CH_LF && recent_reg[7:0] == CH_CR &&
                    in_byte == CH_LF;
        term      = count_reg >= max_host_len || in_byte == CH_NUL ||
                    in_byte == CH_CR || in_byte == CH_LF;
        w         = {host_hist_reg, in_byte};
        cnt_v     = count_reg;

        case (phase_reg)
            PH_SEARCH:
            begin
                recent_next = {recent_reg[31:0], in_byte};
                if (in_byte == CH_NUL || blank_hit)
                begin
                    e.has_sum  = 1'b1;
                    phase_next = PH_DONE;
                end
                else if (host_hit)
                begin
                    if (in_last)
                    begin
                        e.has_sum = 1'b1;
                    end
                    else if (max_host_len == 8'd0)
                    begin
                        e.has_sum  = 1'b1;
                        e.found    = 1'b1;
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        phase_next = PH_CAPTURE;
                    end
                end
                else if (in_last)
                begin
                    e.has_sum = 1'b1;
                end
            end
            PH_CAPTURE:
            begin
                if (term)
                begin
                    e.has_sum  = 1'b1;
                    e.found    = 1'b1;
                    phase_next = PH_DONE;
                end
                else
                begin
                    if (in_byte != CH_SP)
                    begin
                        e.has_char     = 1'b1;
                        e.host_char    = in_byte;
                        host_hist_next = w[23:0];
                        if (w == WORD_MAIL)
                        begin
                            mail_next = 1'b1;
                        end
                        if (w[23:0] == WORD_ONE_EIGHT_NINE)
                        begin
                            one89_next = 1'b1;
                        end
                        if (w == WORD_TWO_ONE_CN)
                        begin
                            cn_next = 1'b1;
                        end
                        cnt_v = count_reg + 8'd1;
                    end
                    count_next = cnt_v;
                    if (cnt_v >= max_host_len || in_last)
                    begin
                        e.has_sum  = 1'b1;
                        e.found    = 1'b1;
                        phase_next = PH_DONE;
                    end
                end
            end
            default:
            begin
                // done: wait for the final byte
            end
        endcase

        e.mail    = e.found && mail_check_enable && mail_next;
        e.special = e.mail && (one89_next || cn_next);

        if (in_last)
        begin
            phase_next     = PH_SEARCH;
            recent_next    = '0;
            count_next     = '0;
            host_hist_next = '0;
            mail_next      = 1'b0;
            one89_next     = 1'b0;
            cn_next        = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SEARCH;
            recent_reg    <= '0;
            count_reg     <= '0;
            host_hist_reg <= '0;
            mail_reg      <= 1'b0;
            one89_reg     <= 1'b0;
            cn_reg        <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            recent_reg    <= recent_next;
            count_reg     <= count_next;
            host_hist_reg <= host_hist_next;
            mail_reg      <= mail_next;
            one89_reg     <= one89_next;
            cn_reg        <= cn_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/hhe_fifo.sv @@
`default_nettype none

module hhe_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  hhe_pkg::result_evt_t din,
    input  logic                 pop,
    output hhe_pkg::result_evt_t dout,
    output logic                 full,
    output logic                 empty
);
    import hhe_pkg::*;

    result_evt_t        slot_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_AW:0]   count_reg;

    assign full  = count_reg == FIFO_AW'(0) + (FIFO_AW+1)'(FIFO_DEPTH);
    assign empty = count_reg == '0;
    assign dout  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + (FIFO_AW+1)'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - (FIFO_AW+1)'(1);
            end
        end
    end

endmodule

`default_nettype wire

@@ sv/hhe_back.sv @@
`default_nettype none

module hhe_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_empty,
    input  hhe_pkg::result_evt_t           q_head,
    output logic                           q_pop,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [hhe_pkg::OUT_DATA_W-1:0] out_data,
    output logic                           out_kind,
    output logic                           out_last
);
    import hhe_pkg::*;

    logic                  valid_reg, valid_next;
    logic                  pend_reg, pend_next;
    logic [OUT_DATA_W-1:0] data_reg, data_next;
    logic                  kind_reg, kind_next;
    logic                  last_reg, last_next;
    logic [2:0]            pend_flags_reg, pend_flags_next;
    logic                  load_ok;

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_kind  = kind_reg;
    assign out_last  = last_reg;
    assign load_ok   = !valid_reg || out_ready;

    always_comb
    begin
        valid_next      = valid_reg;
        pend_next       = pend_reg;
        data_next       = data_reg;
        kind_next       = kind_reg;
        last_next       = last_reg;
        pend_flags_next = pend_flags_reg;
        q_pop           = 1'b0;

        if (load_ok)
        begin
            valid_next = 1'b0;
            if (pend_reg)
            begin
                // summary held back behind a host character
                valid_next = 1'b1;
                kind_next  = 1'b1;
                last_next  = 1'b1;
                data_next  = {(OUT_DATA_W-11)'(0), pend_flags_reg, 8'h00};
                pend_next  = 1'b0;
            end
            else if (!q_empty)
            begin
                q_pop      = 1'b1;
                valid_next = 1'b1;
                if (q_head.has_char)
                begin
                    kind_next       = 1'b0;
                    last_next       = !q_head.has_sum;
                    data_next       = {(OUT_DATA_W-8)'(0), q_head.host_char};
                    pend_next       = q_head.has_sum;
                    pend_flags_next = {q_head.special, q_head.mail, q_head.found};
                end
                else
                begin
                    kind_next = 1'b1;
                    last_next = 1'b1;
                    data_next = {(OUT_DATA_W-11)'(0), q_head.special, q_head.mail,
                                 q_head.found, 8'h00};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg       <= data_next;
        kind_reg       <= kind_next;
        last_reg       <= last_next;
        pend_flags_reg <= pend_flags_next;
    end

endmodule

`default_nettype wire

@@ sv/http_host_header_extractor.sv @@
// HTTP Host header extractor.
// Input stream (s_axis_*): one request byte per beat, tlast on the final byte
// of a request. Output stream (m_axis_*): result beats; tuser = 0 for a
// captured host character, 1 for the per-request summary (found, mail and
// special flags). tlast marks the last result caused by one input byte.
// Config: APB, register 0 at 0x0 = max_host_len (reset 64), register 1 at
// 0x4 = mail_check_enable (reset 1). Write only while the block is idle.
// Throughput: one input byte per cycle while the event queue is not full.
// Each byte gives at most two result beats; the output register sends one
// beat per cycle while m_axis_tready is high, so a byte with both a
// character and a summary takes two output beats, absorbed by the
// four-entry event queue between the parser and the output stage. The
// parser writes the queue on the edge that takes the byte; the output stage
// loads its register from the queue once that register is free, and a
// summary held behind a character follows the character beat.
// Reset: registers return to their reset values, parser to searching, queue
// and output register empty. When m_axis_tready is low the output beat holds,
// the queue fills, and s_axis_tready drops once it is full; nothing is lost.
`default_nettype none

module http_host_header_extractor (
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // request bytes
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // end_of_request
    // results
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] host_char, [8] host_found,
                                        // [9] is_mail, [10] is_special, rest 0
    output logic        m_axis_tuser,   // kind
    output logic        m_axis_tlast    // run_end
);
    import hhe_pkg::*;

    logic [7:0]  max_len_reg;
    logic        mail_en_reg;
    logic        cfg_wr;

    result_evt_t push_evt, head_evt;
    logic        push, pop, q_full, q_empty;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= MAX_HOST_LEN_RESET;
            mail_en_reg <= MAIL_EN_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_MAX_HOST_LEN: max_len_reg <= pwdata[7:0];
                REG_MAIL_EN:      mail_en_reg <= pwdata[0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_MAX_HOST_LEN: prdata = {24'h0, max_len_reg};
            REG_MAIL_EN:      prdata = {31'h0, mail_en_reg};
            default:          prdata = '0;
        endcase
    end

    // front: parse and classify each byte
    hhe_front u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .max_host_len      (max_len_reg),
        .mail_check_enable (mail_en_reg),
        .in_valid          (s_axis_tvalid),
        .in_ready          (s_axis_tready),
        .in_byte           (s_axis_tdata),
        .in_last           (s_axis_tlast),
        .q_full            (q_full),
        .evt_push          (push),
        .evt               (push_evt)
    );

    // decoupling queue of result events
    hhe_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (push_evt),
        .pop   (pop),
        .dout  (head_evt),
        .full  (q_full),
        .empty (q_empty)
    );

    // back: split events into output beats
    hhe_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_head    (head_evt),
        .q_pop     (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_kind  (m_axis_tuser),
        .out_last  (m_axis_tlast)
    );

endmodule

`default_nettype wire

@@ sv/hhe_checker.sv @@
`default_nettype none
`include "assert_macros.svh"

module hhe_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast
);

    // stalled beat holds
    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))

    // a character beat carries no summary flags
    `ASSERT_SAME(a_char_no_flags, clk, rst_n, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[15:8] == 8'h00)

    // a summary closes its run and carries no character
    `ASSERT_SAME(a_sum_last, clk, rst_n, m_axis_tvalid && m_axis_tuser, m_axis_tlast && m_axis_tdata[7:0] == 8'h00 && m_axis_tdata[15:11] == 5'h00)

    // special needs mail, mail needs found
    `ASSERT_SAME(a_flag_order, clk, rst_n, m_axis_tvalid && m_axis_tuser, (!m_axis_tdata[10] || m_axis_tdata[9]) && (!m_axis_tdata[9] || m_axis_tdata[8]))

endmodule

bind http_host_header_extractor hhe_checker u_checker (.*);

`default_nettype wire
